### rtl/core/esud_pkg.sv
package esud_pkg;

    // reciprocals for exact division by multiply and shift
    localparam logic [30:0] RecipDiv60A  = 31'd1145324613;  // (x>>2)*R>>34, x < 2^32
    localparam logic [25:0] RecipDiv60B  = 26'd35791395;    // (x>>2)*R>>29, x < 2^27
    localparam logic [18:0] RecipDiv24   = 19'd349526;      // (x>>3)*R>>20, x < 2^21
    localparam logic [17:0] RecipDiv7    = 18'd149797;      // x*R>>20, x < 2^17
    localparam logic [16:0] RecipDiv1461 = 17'd91868;       // x*R>>27, x < 2^16

    localparam logic [5:0]  SecsPerMin    = 6'd60;
    localparam logic [5:0]  MinsPerHour   = 6'd60;
    localparam logic [4:0]  HoursPerDay   = 5'd24;
    localparam logic [2:0]  DaysPerWeek   = 3'd7;
    localparam logic [16:0] EpochWeekday  = 17'd4;

    // day count rebased to 1968-01-01 so that four-year blocks start on a leap year
    localparam logic [15:0] DaysFrom1968  = 16'd731;
    // 2100-03-01 on that count; from here on a phantom 29 February is skipped
    localparam logic [15:0] SkipLeapDay   = 16'd48272;
    localparam logic [10:0] DaysPer4Years = 11'd1461;
    localparam logic [10:0] BlockYear1    = 11'd366;
    localparam logic [10:0] BlockYear2    = 11'd731;
    localparam logic [10:0] BlockYear3    = 11'd1096;
    localparam logic [7:0]  YearBase1968  = 8'd68;
    localparam logic [7:0]  Year2100      = 8'd200;
    localparam logic [8:0]  FirstOfMarch  = 9'd60;

    typedef struct packed {
        logic        neg;
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [15:0] days;
    } tod_t;

    typedef struct packed {
        logic [2:0] weekday;
        logic [8:0] day_of_year;
        logic [3:0] month;
        logic [4:0] day_of_month;
        logic [7:0] years_since_1900;
    } date_t;

    function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
        logic [8:0] base;
        unique case (m)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
        endcase
        if (leap && (m >= 4'd2))
        begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage

### rtl/core/esud_tod.sv
module esud_tod (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_vld,
    input  logic               in_neg,
    input  logic [31:0]        in_secs,
    output logic               out_vld,
    output esud_pkg::tod_t     out_tod
);

    logic [3:0]  vld_reg;
    logic [3:0]  vld_next;

    logic        neg_a_reg;
    logic [5:0]  secs_a_reg;
    logic [26:0] q1_a_reg;
    logic [26:0] q1_a_next;

    logic        neg_b_reg;
    logic [5:0]  sec_b_reg;
    logic [5:0]  sec_b_next;
    logic [5:0]  min0_b_reg;
    logic [20:0] q2_b_reg;
    logic [20:0] q2_b_next;

    logic        neg_c_reg;
    logic [5:0]  sec_c_reg;
    logic [5:0]  min_c_reg;
    logic [5:0]  min_c_next;
    logic [4:0]  hr0_c_reg;
    logic [15:0] days_c_reg;
    logic [15:0] days_c_next;

    esud_pkg::tod_t tod_d_reg;
    esud_pkg::tod_t tod_d_next;

    logic [60:0] prod_a;
    logic [50:0] prod_b;
    logic [36:0] prod_c;
    logic [11:0] q1x60;
    logic [11:0] q2x60;
    logic [9:0]  dx24;

    always_comb
    begin
        vld_next    = {vld_reg[2:0], in_vld};

        prod_a      = 61'(in_secs[31:2]) * 61'(esud_pkg::RecipDiv60A);
        q1_a_next   = prod_a[60:34];

        q1x60       = 12'(q1_a_reg[5:0]) * 12'(esud_pkg::SecsPerMin);
        sec_b_next  = secs_a_reg - q1x60[5:0];
        prod_b      = 51'(q1_a_reg[26:2]) * 51'(esud_pkg::RecipDiv60B);
        q2_b_next   = prod_b[49:29];

        q2x60       = 12'(q2_b_reg[5:0]) * 12'(esud_pkg::MinsPerHour);
        min_c_next  = min0_b_reg - q2x60[5:0];
        prod_c      = 37'(q2_b_reg[20:3]) * 37'(esud_pkg::RecipDiv24);
        days_c_next = prod_c[35:20];

        dx24              = 10'(days_c_reg[4:0]) * 10'(esud_pkg::HoursPerDay);
        tod_d_next.neg    = neg_c_reg;
        tod_d_next.second = sec_c_reg;
        tod_d_next.minute = min_c_reg;
        tod_d_next.hour   = hr0_c_reg - dx24[4:0];
        tod_d_next.days   = days_c_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            neg_a_reg  <= in_neg;
            secs_a_reg <= in_secs[5:0];
            q1_a_reg   <= q1_a_next;

            neg_b_reg  <= neg_a_reg;
            sec_b_reg  <= sec_b_next;
            min0_b_reg <= q1_a_reg[5:0];
            q2_b_reg   <= q2_b_next;

            neg_c_reg  <= neg_b_reg;
            sec_c_reg  <= sec_b_reg;
            min_c_reg  <= min_c_next;
            hr0_c_reg  <= q2_b_reg[4:0];
            days_c_reg <= days_c_next;

            tod_d_reg  <= tod_d_next;
        end
    end

    assign out_vld = vld_reg[3];
    assign out_tod = tod_d_reg;

endmodule

### rtl/core/esud_cal.sv
module esud_cal (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_vld,
    input  esud_pkg::tod_t     in_tod,
    output logic               out_vld,
    output esud_pkg::tod_t     out_tod,
    output esud_pkg::date_t    out_date
);

    logic [5:0]  vld_reg;
    logic [5:0]  vld_next;

    // weekday and rebased day count
    esud_pkg::tod_t tod_e_reg;
    logic [2:0]  w_e_reg;
    logic [2:0]  wq_e_reg;
    logic [15:0] dp_e_reg;
    logic [15:0] dp_e_next;
    logic [16:0] w_e;
    logic [34:0] prod_e;
    logic [15:0] dp_raw;

    // four-year block number
    esud_pkg::tod_t tod_f_reg;
    logic [2:0]  wd_f_reg;
    logic [2:0]  wd_f_next;
    logic [15:0] dp_f_reg;
    logic [5:0]  n4_f_reg;
    logic [32:0] prod_f;
    logic [5:0]  wq7;

    // day within block
    esud_pkg::tod_t tod_g_reg;
    logic [2:0]  wd_g_reg;
    logic [5:0]  n4_g_reg;
    logic [10:0] r_g_reg;
    logic [10:0] r_g_next;
    logic [15:0] blk_days;
    logic [15:0] r_full;

    // year and day of year in the four-year calendar
    esud_pkg::tod_t tod_h_reg;
    logic [2:0]  wd_h_reg;
    logic [7:0]  year_h_reg;
    logic [7:0]  year_h_next;
    logic [1:0]  yi_h_reg;
    logic [1:0]  yi_h_next;
    logic [8:0]  doyf_h_reg;
    logic [10:0] doyf_h_next;

    // true day of year, leap flag, month
    esud_pkg::tod_t tod_i_reg;
    logic [2:0]  wd_i_reg;
    logic [7:0]  year_i_reg;
    logic [8:0]  doy_i_reg;
    logic [8:0]  doy_i_next;
    logic [3:0]  mon_i_reg;
    logic [3:0]  mon_i_next;
    logic        leap_i_reg;
    logic        leap_i_next;

    esud_pkg::tod_t  tod_j_reg;
    esud_pkg::date_t date_j_reg;
    esud_pkg::date_t date_j_next;
    logic [8:0]      dom_raw;

    always_comb
    begin
        vld_next  = {vld_reg[4:0], in_vld};

        w_e       = 17'(in_tod.days) + esud_pkg::EpochWeekday;
        prod_e    = 35'(w_e) * 35'(esud_pkg::RecipDiv7);
        dp_raw    = in_tod.days + esud_pkg::DaysFrom1968;
        dp_e_next = (dp_raw >= esud_pkg::SkipLeapDay) ? (dp_raw + 16'd1) : dp_raw;

        wq7       = 6'(wq_e_reg) * 6'(esud_pkg::DaysPerWeek);
        wd_f_next = w_e_reg - wq7[2:0];
        prod_f    = 33'(dp_e_reg) * 33'(esud_pkg::RecipDiv1461);

        blk_days  = 16'(n4_f_reg) * 16'(esud_pkg::DaysPer4Years);
        r_full    = dp_f_reg - blk_days;
        r_g_next  = r_full[10:0];

        if (r_g_reg < esud_pkg::BlockYear1)
        begin
            yi_h_next   = 2'd0;
            doyf_h_next = r_g_reg;
        end
        else if (r_g_reg < esud_pkg::BlockYear2)
        begin
            yi_h_next   = 2'd1;
            doyf_h_next = r_g_reg - esud_pkg::BlockYear1;
        end
        else if (r_g_reg < esud_pkg::BlockYear3)
        begin
            yi_h_next   = 2'd2;
            doyf_h_next = r_g_reg - esud_pkg::BlockYear2;
        end
        else
        begin
            yi_h_next   = 2'd3;
            doyf_h_next = r_g_reg - esud_pkg::BlockYear3;
        end
        year_h_next = esud_pkg::YearBase1968 + {n4_g_reg, yi_h_next};

        // 2100 is no leap year: undo the skipped day from March on
        leap_i_next = (yi_h_reg == 2'd0) && (year_h_reg != esud_pkg::Year2100);
        if ((year_h_reg == esud_pkg::Year2100) && (doyf_h_reg >= esud_pkg::FirstOfMarch))
        begin
            doy_i_next = doyf_h_reg - 9'd1;
        end
        else
        begin
            doy_i_next = doyf_h_reg;
        end
        mon_i_next = 4'd0;
        for (int k = 1; k < 12; k++)
        begin
            if (doy_i_next >= esud_pkg::month_start(4'(k), leap_i_next))
            begin
                mon_i_next = 4'(k);
            end
        end

        dom_raw                      = doy_i_reg - esud_pkg::month_start(mon_i_reg, leap_i_reg)
                                       + 9'd1;
        date_j_next.weekday          = wd_i_reg;
        date_j_next.day_of_year      = doy_i_reg;
        date_j_next.month            = mon_i_reg;
        date_j_next.day_of_month     = dom_raw[4:0];
        date_j_next.years_since_1900 = year_i_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tod_e_reg  <= in_tod;
            w_e_reg    <= w_e[2:0];
            wq_e_reg   <= prod_e[22:20];
            dp_e_reg   <= dp_e_next;

            tod_f_reg  <= tod_e_reg;
            wd_f_reg   <= wd_f_next;
            dp_f_reg   <= dp_e_reg;
            n4_f_reg   <= prod_f[32:27];

            tod_g_reg  <= tod_f_reg;
            wd_g_reg   <= wd_f_reg;
            n4_g_reg   <= n4_f_reg;
            r_g_reg    <= r_g_next;

            tod_h_reg  <= tod_g_reg;
            wd_h_reg   <= wd_g_reg;
            year_h_reg <= year_h_next;
            yi_h_reg   <= yi_h_next;
            doyf_h_reg <= doyf_h_next[8:0];

            tod_i_reg  <= tod_h_reg;
            wd_i_reg   <= wd_h_reg;
            year_i_reg <= year_h_reg;
            doy_i_reg  <= doy_i_next;
            mon_i_reg  <= mon_i_next;
            leap_i_reg <= leap_i_next;

            tod_j_reg  <= tod_i_reg;
            date_j_reg <= date_j_next;
        end
    end

    assign out_vld  = vld_reg[5];
    assign out_tod  = tod_j_reg;
    assign out_date = date_j_reg;

endmodule

### rtl/core/epoch_seconds_to_utc_date_top.sv
// Converts signed seconds since 1970-01-01 00:00:00 UTC to a Gregorian UTC date and time.
// Fully pipelined: one beat is taken every cycle unless res_ready stalls it, and
// each result passes the input, time, calendar and output registers in order. The whole
// pipeline advances together, so a stall at the output stops every stage and nothing
// is lost. The stage count comes from the chain of constant divisions (by 60, 60, 24, 7
// and 1461), each done as a reciprocal multiply with its own register stage, followed by
// the year, month and day-of-month steps. A negative input gives ok low and all fields 0.
module epoch_seconds_to_utc_date_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid,
    output logic               ready,
    input  logic signed [32:0] seconds_since_epoch,
    output logic               res_valid,
    input  logic               res_ready,
    output logic               ok,
    output logic [5:0]         second,
    output logic [5:0]         minute,
    output logic [4:0]         hour,
    output logic [2:0]         weekday,
    output logic [8:0]         day_of_year,
    output logic [3:0]         month,
    output logic [4:0]         day_of_month,
    output logic [7:0]         years_since_1900
);

    logic            adv;
    logic            vld_in_reg;
    logic            neg_in_reg;
    logic [31:0]     secs_in_reg;

    logic            tod_vld;
    esud_pkg::tod_t  tod;
    logic            cal_vld;
    esud_pkg::tod_t  cal_tod;
    esud_pkg::date_t cal_date;

    logic            res_valid_reg;
    logic            ok_reg;
    logic            ok_next;
    esud_pkg::tod_t  tod_out_reg;
    esud_pkg::tod_t  tod_out_next;
    esud_pkg::date_t date_out_reg;
    esud_pkg::date_t date_out_next;

    assign adv   = !res_valid_reg || res_ready;
    assign ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_in_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_in_reg    <= valid;
            res_valid_reg <= cal_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            neg_in_reg   <= seconds_since_epoch[32];
            secs_in_reg  <= seconds_since_epoch[31:0];
            ok_reg       <= ok_next;
            tod_out_reg  <= tod_out_next;
            date_out_reg <= date_out_next;
        end
    end

    esud_tod u_tod (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_vld  (vld_in_reg),
        .in_neg  (neg_in_reg),
        .in_secs (secs_in_reg),
        .out_vld (tod_vld),
        .out_tod (tod)
    );

    esud_cal u_cal (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (tod_vld),
        .in_tod   (tod),
        .out_vld  (cal_vld),
        .out_tod  (cal_tod),
        .out_date (cal_date)
    );

    // negative input: every field cleared
    always_comb
    begin
        ok_next = !cal_tod.neg;
        if (cal_tod.neg)
        begin
            tod_out_next  = '0;
            date_out_next = '0;
        end
        else
        begin
            tod_out_next  = cal_tod;
            date_out_next = cal_date;
        end
    end

    assign res_valid        = res_valid_reg;
    assign ok               = ok_reg;
    assign second           = tod_out_reg.second;
    assign minute           = tod_out_reg.minute;
    assign hour             = tod_out_reg.hour;
    assign weekday          = date_out_reg.weekday;
    assign day_of_year      = date_out_reg.day_of_year;
    assign month            = date_out_reg.month;
    assign day_of_month     = date_out_reg.day_of_month;
    assign years_since_1900 = date_out_reg.years_since_1900;

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !ok) |-> (second == 6'd0 && hour == 5'd0 && month == 4'd0
                                && day_of_month == 5'd0 && years_since_1900 == 8'd0))
        else $error("error beat carries non-zero fields");

    a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && ok) |-> (second < 6'd60 && minute < 6'd60 && hour < 5'd24
                               && weekday < 3'd7 && month < 4'd12 && day_of_month != 5'd0
                               && years_since_1900 >= 8'd70))
        else $error("result field out of range");

    a_january: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && ok && month == 4'd0) |-> (day_of_year == 9'(day_of_month) - 9'd1))
        else $error("day of year disagrees with day of month in January");

endmodule
